>>> rtl/ldi_pkg.sv
// Shared types and constants for the light direction and intensity block.
`default_nettype none

package ldi_pkg;

   localparam int COORD_W = 16;
   localparam int DIST_W  = 18;
   localparam int EXP_W   = 5;
   localparam int CSR_W   = 48;
   localparam int CSR_A_W = 3;

   localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};
   localparam logic [15:0]       ONE_Q14  = 16'd16384;

   typedef enum logic [1:0] {
      KIND_DIRECTIONAL = 2'd0,
      KIND_POINT       = 2'd1,
      KIND_SPOT        = 2'd2,
      KIND_SPOT_ALT    = 2'd3
   } kind_type;

   typedef enum logic [CSR_A_W-1:0] {
      CSR_KIND      = 3'd0,
      CSR_POSITION  = 3'd1,
      CSR_DIRECTION = 3'd2,
      CSR_COLOR     = 3'd3,
      CSR_ATTEN     = 3'd4,
      CSR_CUTOFF    = 3'd5,
      CSR_EXPONENT  = 3'd6,
      CSR_UNUSED    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic                      lit;
      logic signed [15:0]        dir_x;
      logic signed [15:0]        dir_y;
      logic signed [15:0]        dir_z;
      logic [DIST_W-1:0]         distance;
      logic [15:0]               intensity_red;
      logic [15:0]               intensity_green;
      logic [15:0]               intensity_blue;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/ldi_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module ldi_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 25,
   parameter int QUO_W = 15
) (
   input  wire logic             clock,
   input  wire logic             adv,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [QUO_W-1:0] quo
);

   localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [CW-1:0]    rem_ff  [QUO_W];
   logic [CW-1:0]    rem_in  [QUO_W];
   logic [CW-1:0]    rem_src [QUO_W];
   logic [DEN_W-1:0] den_ff  [QUO_W];
   logic [DEN_W-1:0] den_in  [QUO_W];
   logic [QUO_W-1:0] quo_ff  [QUO_W];
   logic [QUO_W-1:0] quo_in  [QUO_W];
   logic [QUO_W-1:0] quo_src [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_step
      localparam int BIT = QUO_W - 1 - j;
      logic [CW-1:0] cand;

      if (j == 0) begin : g_first
         assign rem_src[j] = CW'(num);
         assign den_in[j]  = den;
         assign quo_src[j] = '0;
      end else begin : g_next
         assign rem_src[j] = rem_ff[j-1];
         assign den_in[j]  = den_ff[j-1];
         assign quo_src[j] = quo_ff[j-1];
      end

      assign cand = CW'(den_in[j]) << BIT;

      always_comb begin
         if (rem_src[j] >= cand) begin
            rem_in[j] = rem_src[j] - cand;
            quo_in[j] = quo_src[j] | (QUO_W'(1) << BIT);
         end else begin
            rem_in[j] = rem_src[j];
            quo_in[j] = quo_src[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         den_ff <= den_in;
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

`default_nettype wire

>>> rtl/light_direction_and_intensity.sv
// Top level: per-point light direction, distance and intensity pipeline.
//
// Usage: configure the light through the csr_ port (csr_we, csr_addr,
// csr_wdata) while no items are in flight; each write takes effect at once.
// Items enter on req_ (valid/ready) as one surface point each and leave on
// rsp_ (valid/ready) as one result each, in order.
// Throughput: one item per cycle while the output queue is not full.
// The datapath is a 97-stage pipeline: an integer square root at one result
// bit per stage, a direction divider at one quotient bit per stage, one
// multiply per stage for the spot power (one stage per possible exponent
// step) and an intensity divider at one quotient bit per stage.
// Output: a result is written into the two-entry output queue as its item
// leaves the last pipeline stage and shows on rsp_valid from that write on
// until rsp_ready takes it.
// Stall: the pipeline advances while the output queue has a free entry, so
// req_ready stays high while one finished result waits; with the queue full
// the whole pipeline holds and req_ready drops.
// Reset: clears the pipeline valid bits and the queue, and loads the light
// registers with a point light, quadratic attenuation 1.0 and exponent 1.
`default_nettype none

module light_direction_and_intensity
   import ldi_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   input  wire logic               csr_we,
   input  wire logic [CSR_A_W-1:0] csr_addr,
   input  wire logic [CSR_W-1:0]   csr_wdata
);

   localparam int SQ_STEPS = 25;
   localparam int DIR_QW   = 15;
   localparam int PW_STEPS = (1 << EXP_W) - 1;
   localparam int INT_QW   = 16;
   localparam int ST_V     = 0;
   localparam int ST_SQ    = 1;
   localparam int ST_SUM   = 2;
   localparam int ST_RT0   = 3;
   localparam int ST_DN    = ST_RT0 + SQ_STEPS;
   localparam int ST_ATT   = ST_DN + 1;
   localparam int ST_DIR   = ST_DN + DIR_QW + 1;
   localparam int ST_PROD  = ST_DIR + 1;
   localparam int ST_COS   = ST_PROD + 1;
   localparam int ST_MAG   = ST_COS + 1;
   localparam int ST_PW0   = ST_MAG + 1;
   localparam int ST_NUM   = ST_PW0 + PW_STEPS;
   localparam int ST_SAT   = ST_NUM + 1;
   localparam int DEPTH    = ST_SAT + INT_QW + 1;

   typedef struct packed {
      logic [2:0][16:0] v;
      logic [2:0][31:0] sq;
      logic [49:0]      sx;
      logic [49:0]      sr;
      logic [24:0]      len;
      logic [2:0][39:0] dnum;
      logic [16:0]      dlen;
      logic [33:0]      att1;
      logic [51:0]      att;
      logic [2:0][15:0] dir;
      logic [2:0][31:0] prod;
      logic [33:0]      cosv;
      logic             unlit;
      logic             cneg;
      logic [14:0]      mag;
      logic [14:0]      pm;
      logic [2:0][40:0] inum;
      logic [51:0]      iden;
      logic [2:0]       isat;
      logic [2:0]       izero;
   } pl_type;

   // light registers
   kind_type    kind_ff;
   logic [47:0] pos_ff;
   logic [47:0] ldir_ff;
   logic [47:0] color_ff;
   logic [47:0] atten_ff;
   logic [15:0] cutoff_ff;
   logic [EXP_W-1:0] exp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_POINT;
         pos_ff    <= '0;
         ldir_ff   <= '0;
         color_ff  <= '0;
         atten_ff  <= 48'd256;
         cutoff_ff <= '0;
         exp_ff    <= EXP_W'(1);
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_KIND:      kind_ff   <= kind_type'(csr_wdata[1:0]);
            CSR_POSITION:  pos_ff    <= csr_wdata;
            CSR_DIRECTION: ldir_ff   <= csr_wdata;
            CSR_COLOR:     color_ff  <= csr_wdata;
            CSR_ATTEN:     atten_ff  <= csr_wdata;
            CSR_CUTOFF:    cutoff_ff <= csr_wdata[15:0];
            CSR_EXPONENT:  exp_ff    <= csr_wdata[EXP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // pipeline
   logic             adv;
   logic [DEPTH-1:0] vld_ff;
   pl_type           pl_ff [DEPTH];
   pl_type           pl_in [DEPTH];
   logic [2:0][DIR_QW-1:0] dq;
   logic [2:0][INT_QW-1:0] iq;
   logic [2:0][15:0]       pt;

   assign pt = {req_data.point_z, req_data.point_y, req_data.point_x};

   for (genvar k = 0; k < DEPTH; k++) begin : g_st
      if (k == ST_V) begin : g_v
         always_comb begin
            pl_in[k] = '0;
            for (int i = 0; i < 3; i++) begin
               if (kind_ff == KIND_DIRECTIONAL) begin
                  pl_in[k].v[i] = 17'd0 - {ldir_ff[16*i+15], ldir_ff[16*i +: 16]};
               end else begin
                  pl_in[k].v[i] = {pos_ff[16*i+15], pos_ff[16*i +: 16]}
                                - {pt[i][15], pt[i]};
               end
            end
         end
      end else if (k == ST_SQ) begin : g_sq
         always_comb begin
            logic signed [33:0] p;
            pl_in[k] = pl_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               p = $signed(pl_ff[k-1].v[i]) * $signed(pl_ff[k-1].v[i]);
               pl_in[k].sq[i] = p[31:0];
            end
         end
      end else if (k == ST_SUM) begin : g_sum
         always_comb begin
            logic [33:0] s;
            pl_in[k] = pl_ff[k-1];
            s = 34'(pl_ff[k-1].sq[0]) + 34'(pl_ff[k-1].sq[1]) + 34'(pl_ff[k-1].sq[2]);
            pl_in[k].sx = {s, 16'd0};
            pl_in[k].sr = '0;
         end
      end else if (k >= ST_RT0 && k < ST_RT0 + SQ_STEPS) begin : g_rt
         localparam logic [49:0] B = 50'd1 << (2 * (ST_RT0 + SQ_STEPS - 1 - k));
         always_comb begin
            logic [50:0] t;
            pl_in[k] = pl_ff[k-1];
            t = {1'b0, pl_ff[k-1].sr} + {1'b0, B};
            if ({1'b0, pl_ff[k-1].sx} >= t) begin
               pl_in[k].sx = pl_ff[k-1].sx - t[49:0];
               pl_in[k].sr = (pl_ff[k-1].sr >> 1) + B;
            end else begin
               pl_in[k].sr = pl_ff[k-1].sr >> 1;
            end
         end
      end else if (k == ST_DN) begin : g_dn
         always_comb begin
            logic [16:0] m;
            logic [24:0] ln;
            logic [16:0] ds;
            pl_in[k] = pl_ff[k-1];
            ln = pl_ff[k-1].sr[24:0];
            ds = ln[24:8];
            pl_in[k].len  = ln;
            pl_in[k].dlen = ds;
            for (int i = 0; i < 3; i++) begin
               m = pl_ff[k-1].v[i][16] ? 17'd0 - pl_ff[k-1].v[i] : pl_ff[k-1].v[i];
               pl_in[k].dnum[i] = {1'b0, m, 22'd0} + 40'(ln >> 1);
            end
            pl_in[k].att1 = 34'(atten_ff[15:0]) * 34'(ds) + 34'({atten_ff[31:16], 8'd0});
         end
      end else if (k == ST_ATT) begin : g_att
         always_comb begin
            pl_in[k] = pl_ff[k-1];
            pl_in[k].att = 52'(pl_ff[k-1].att1) * 52'(pl_ff[k-1].dlen)
                         + 52'({atten_ff[47:32], 16'd0});
         end
      end else if (k == ST_DIR) begin : g_dir
         always_comb begin
            logic [15:0] qv;
            pl_in[k] = pl_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               qv = (16'(dq[i]) > ONE_Q14) ? ONE_Q14 : 16'(dq[i]);
               if (pl_ff[k-1].len == '0) begin
                  pl_in[k].dir[i] = '0;
               end else if (pl_ff[k-1].v[i][16]) begin
                  pl_in[k].dir[i] = 16'd0 - qv;
               end else begin
                  pl_in[k].dir[i] = qv;
               end
            end
         end
      end else if (k == ST_PROD) begin : g_prod
         always_comb begin
            pl_in[k] = pl_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               pl_in[k].prod[i] = $signed(pl_ff[k-1].dir[i]) * $signed(ldir_ff[16*i +: 16]);
            end
         end
      end else if (k == ST_COS) begin : g_cos
         always_comb begin
            logic signed [33:0] s;
            pl_in[k] = pl_ff[k-1];
            s = $signed(pl_ff[k-1].prod[0]) + $signed(pl_ff[k-1].prod[1])
              + $signed(pl_ff[k-1].prod[2]);
            pl_in[k].cosv = 34'd0 - s;
         end
      end else if (k == ST_MAG) begin : g_mag
         always_comb begin
            logic [33:0] cut;
            logic [33:0] a;
            logic [19:0] m;
            pl_in[k] = pl_ff[k-1];
            cut = {{4{cutoff_ff[15]}}, cutoff_ff, 14'd0};
            pl_in[k].unlit = $signed(pl_ff[k-1].cosv) < $signed(cut);
            pl_in[k].cneg  = pl_ff[k-1].cosv[33];
            a = pl_ff[k-1].cosv[33] ? 34'd0 - pl_ff[k-1].cosv : pl_ff[k-1].cosv;
            m = a[33:14];
            pl_in[k].mag = (m > 20'(ONE_Q14)) ? ONE_Q14[14:0] : m[14:0];
            pl_in[k].pm  = ONE_Q14[14:0];
         end
      end else if (k >= ST_PW0 && k < ST_PW0 + PW_STEPS) begin : g_pw
         localparam logic [EXP_W-1:0] E = EXP_W'(k - ST_PW0);
         always_comb begin
            logic [29:0] p;
            pl_in[k] = pl_ff[k-1];
            p = 30'(pl_ff[k-1].pm) * 30'(pl_ff[k-1].mag);
            if (E < exp_ff) begin
               pl_in[k].pm = p[28:14];
            end
         end
      end else if (k == ST_NUM) begin : g_num
         always_comb begin
            logic pneg;
            pl_in[k] = pl_ff[k-1];
            pneg = pl_ff[k-1].cneg & exp_ff[0];
            for (int i = 0; i < 3; i++) begin
               if (kind_ff == KIND_POINT) begin
                  pl_in[k].inum[i] = {1'b0, color_ff[16*i +: 16], 24'd0};
               end else if (pneg) begin
                  pl_in[k].inum[i] = '0;
               end else begin
                  pl_in[k].inum[i] = {31'(color_ff[16*i +: 16]) * 31'(pl_ff[k-1].pm), 10'd0};
               end
            end
            if (kind_ff == KIND_POINT && pl_ff[k-1].att < 52'(25'd1 << 24)) begin
               pl_in[k].iden = 52'(25'd1 << 24);
            end else begin
               pl_in[k].iden = pl_ff[k-1].att;
            end
         end
      end else if (k == ST_SAT) begin : g_sat
         always_comb begin
            pl_in[k] = pl_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               pl_in[k].izero[i] = (pl_ff[k-1].inum[i] == '0);
               pl_in[k].isat[i]  = 68'(pl_ff[k-1].inum[i]) >= {pl_ff[k-1].iden, 16'd0};
            end
         end
      end else begin : g_carry
         assign pl_in[k] = pl_ff[k-1];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_div
      ldi_div #(.NUM_W(40), .DEN_W(25), .QUO_W(DIR_QW)) u_dir_div (
         .clock (clock),
         .adv   (adv),
         .num   (pl_ff[ST_DN].dnum[i]),
         .den   (pl_ff[ST_DN].len),
         .quo   (dq[i])
      );
      ldi_div #(.NUM_W(41), .DEN_W(52), .QUO_W(INT_QW)) u_int_div (
         .clock (clock),
         .adv   (adv),
         .num   (pl_ff[ST_SAT].inum[i]),
         .den   (pl_ff[ST_SAT].iden),
         .quo   (iq[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff <= pl_in;
      end
   end

   // result assembly
   rsp_type     res;
   pl_type      last;
   logic [2:0][15:0] inten;

   assign last = pl_ff[DEPTH-1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (kind_ff == KIND_DIRECTIONAL) begin
            inten[i] = color_ff[16*i +: 16];
         end else if ((kind_ff != KIND_POINT && last.unlit) || last.izero[i]) begin
            inten[i] = '0;
         end else if (last.isat[i]) begin
            inten[i] = 16'hFFFF;
         end else begin
            inten[i] = iq[i];
         end
      end
      res.lit             = (kind_ff == KIND_DIRECTIONAL) || (kind_ff == KIND_POINT)
                          || !last.unlit;
      res.dir_x           = last.dir[0];
      res.dir_y           = last.dir[1];
      res.dir_z           = last.dir[2];
      res.distance        = (kind_ff == KIND_DIRECTIONAL) ? DIST_SAT : {1'b0, last.dlen};
      res.intensity_red   = inten[0];
      res.intensity_green = inten[1];
      res.intensity_blue  = inten[2];
   end

   // output queue
   rsp_type    buf_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push;
   logic       pop;

   assign adv       = (cnt_ff != 2'd2);
   assign req_ready = adv;
   assign push      = adv & vld_ff[DEPTH-1];
   assign pop       = rsp_valid & rsp_ready;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = buf_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

`default_nettype wire

>>> rtl/ldi_checker.sv
// Port-level checker for the light direction and intensity block, with its bind.
`default_nettype none

module ldi_checker
   import ldi_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire req_type            req_data,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire rsp_type            rsp_data,
   input wire logic               csr_we,
   input wire logic [CSR_A_W-1:0] csr_addr,
   input wire logic [CSR_W-1:0]   csr_wdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_dark_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.lit |->
         rsp_data.intensity_red == 16'd0 && rsp_data.intensity_green == 16'd0
         && rsp_data.intensity_blue == 16'd0)
      else $error("unlit item carries intensity");

   a_sat_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.distance == DIST_SAT |-> rsp_data.lit)
      else $error("directional item not lit");

   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         $signed(rsp_data.dir_x) >= -16384 && $signed(rsp_data.dir_x) <= 16384
         && $signed(rsp_data.dir_y) >= -16384 && $signed(rsp_data.dir_y) <= 16384
         && $signed(rsp_data.dir_z) >= -16384 && $signed(rsp_data.dir_z) <= 16384)
      else $error("direction component out of range");

endmodule

bind light_direction_and_intensity ldi_checker u_ldi_checker (.*);

`default_nettype wire
